FILE: hdl/rau_pkg.sv
// Package with shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned OpW  = 32;
  localparam int unsigned MagW = 2 * OpW;
  localparam int unsigned CntW = $clog2(MagW + 2);

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_CMP  = 3'd4;
  localparam logic [2:0] KIND_NORM = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // Capture operands and check them.
    logic mul1;     // First product.
    logic mul2;     // Remaining products.
    logic combine;  // Form numerator and denominator.
    logic gstep;    // One binary gcd step.
    logic dload;    // Start dividing numerator by the gcd.
    logic dstep;    // One restoring division step.
    logic dswap;    // Move to dividing the denominator.
    logic finish;   // Produce the result.
  } rau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;    // Result known after the operand check.
    logic is_cmp;   // Compare takes a shortcut after the products.
    logic unary;    // Normalize skips the products.
    logic gdone;    // Gcd has converged.
    logic ddone;    // Current division is complete.
  } rau_stat_t;

endpackage

FILE: hdl/rau_datapath.sv
// Datapath: products, binary gcd and shift-subtract division for reduction.
module rau_datapath (
  input  logic                     clk,
  input  rau_pkg::rau_cmd_t        cmd,
  input  logic [2:0]               in_kind,
  input  logic [31:0]              in_a_num,
  input  logic [31:0]              in_a_den,
  input  logic [31:0]              in_b_num,
  input  logic [31:0]              in_b_den,
  output rau_pkg::rau_stat_t       stat,
  output logic [31:0]              res_num,
  output logic [30:0]              res_den,
  output logic [1:0]               res_order,
  output logic [1:0]               res_status
);

  localparam int unsigned W = rau_pkg::OpW;
  localparam int unsigned M = rau_pkg::MagW;

  logic [2:0]   kind_r;
  logic [W-1:0] anm_r, adm_r, bnm_r, bdm_r;
  logic         ann_r, adn_r, bnn_r, bdn_r;
  logic [1:0]   early_st_r;
  logic [M-1:0] p0_r, p1_r, p2_r, p3_r;
  logic         p0n_r, p1n_r;
  logic [M-1:0] num_r, den_r;
  logic         nneg_r;
  logic [M-1:0] gu_r, gv_r;
  logic [rau_pkg::CntW-1:0] gk_r;
  logic [M-1:0] g_r;
  logic [M-1:0] q_r, rem_r, nq_r;
  logic [rau_pkg::CntW-1:0] dc_r;
  logic [1:0]   order_r;

  logic [W-1:0] anm, adm, bnm, bdm;
  logic         ann, adn, bnn, bdn;
  logic [M-1:0] sum_mag;
  logic         sum_neg, t_neg;
  logic [M:0]   rem_sh;
  logic [M-1:0] gdiff;

  function automatic logic [W-1:0] mag_of(input logic [31:0] v);
    return v[W-1] ? (~v[W-1:0] + 1'b1) : v[W-1:0];
  endfunction

  assign anm = mag_of(in_a_num);
  assign adm = mag_of(in_a_den);
  assign bnm = mag_of(in_b_num);
  assign bdm = mag_of(in_b_den);
  assign ann = in_a_num[W-1];
  assign adn = in_a_den[W-1];
  assign bnn = in_b_num[W-1];
  assign bdn = in_b_den[W-1];

  // Signed magnitude sum of the two cross-products.
  always_comb begin
    t_neg = p1n_r ^ (kind_r == rau_pkg::KIND_SUB);
    if (p0n_r == t_neg) begin
      sum_mag = p0_r + p1_r;
      sum_neg = p0n_r;
    end else if (p0_r >= p1_r) begin
      sum_mag = p0_r - p1_r;
      sum_neg = p0n_r;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_neg = t_neg;
    end
  end

  assign gdiff  = (gu_r > gv_r) ? (gu_r - gv_r) : (gv_r - gu_r);
  assign rem_sh = {rem_r, q_r[M-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      anm_r <= anm; adm_r <= adm; bnm_r <= bnm; bdm_r <= bdm;
      ann_r <= ann && (anm != '0);
      adn_r <= adn;
      bnn_r <= bnn && (bnm != '0);
      bdn_r <= bdn;
      if (adm == '0 || (in_kind < rau_pkg::KIND_NORM && bdm == '0)) begin
        early_st_r <= rau_pkg::ST_ZDEN;
      end else if (in_kind == rau_pkg::KIND_DIV && bnm == '0) begin
        early_st_r <= rau_pkg::ST_DIV0;
      end else begin
        early_st_r <= rau_pkg::ST_OK;
      end
      order_r <= rau_pkg::ORD_LT;
    end
    if (cmd.mul1) begin
      // an*bd (or an*bn for multiply).
      p0_r  <= M'(anm_r) * M'((kind_r == rau_pkg::KIND_MUL) ? bnm_r : bdm_r);
      p0n_r <= ann_r ^ ((kind_r == rau_pkg::KIND_MUL) ? bnn_r : bdn_r);
    end
    if (cmd.mul2) begin
      p1_r  <= M'(bnm_r) * M'(adm_r);
      p1n_r <= bnn_r ^ adn_r;
      p2_r  <= M'(adm_r) * M'((kind_r == rau_pkg::KIND_DIV) ? bnm_r : bdm_r);
      p3_r  <= '0;
    end
    if (cmd.combine) begin
      if (kind_r == rau_pkg::KIND_CMP) begin
        // Signs normalized to positive denominators.
        logic ln, rn;
        ln = (ann_r ^ adn_r) && (p0_r != '0);
        rn = (bnn_r ^ bdn_r) && (p1_r != '0);
        if (ln != rn) begin
          order_r <= ln ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
        end else if (p0_r == p1_r) begin
          order_r <= rau_pkg::ORD_EQ;
        end else if ((p0_r < p1_r) ^ ln) begin
          order_r <= rau_pkg::ORD_LT;
        end else begin
          order_r <= rau_pkg::ORD_GT;
        end
        num_r <= p3_r;
        den_r <= p3_r;
        nneg_r <= 1'b0;
      end else begin
        logic [M-1:0] n;
        logic         nn, dn;
        if (kind_r >= rau_pkg::KIND_NORM) begin
          n = M'(anm_r); nn = ann_r; dn = adn_r;
          den_r <= M'(adm_r);
        end else if (kind_r == rau_pkg::KIND_ADD || kind_r == rau_pkg::KIND_SUB) begin
          n = sum_mag; nn = sum_neg; dn = adn_r ^ bdn_r;
          den_r <= p2_r;
        end else if (kind_r == rau_pkg::KIND_MUL) begin
          n = p0_r; nn = p0n_r; dn = adn_r ^ bdn_r;
          den_r <= p2_r;
        end else begin
          n = p0_r; nn = p0n_r; dn = adn_r ^ bnn_r;
          den_r <= p2_r;
        end
        num_r  <= n;
        nneg_r <= (nn ^ dn) && (n != '0);
        gu_r   <= n;
        gv_r   <= (kind_r >= rau_pkg::KIND_NORM) ? M'(adm_r) : p2_r;
        gk_r   <= '0;
      end
    end
    if (cmd.gstep) begin
      // Binary gcd: strip common twos, then subtract while both are nonzero.
      if (gu_r == '0) begin
        gu_r <= gv_r;
        gv_r <= '0;
      end else if (!gu_r[0] && !gv_r[0]) begin
        gu_r <= gu_r >> 1; gv_r <= gv_r >> 1; gk_r <= gk_r + 1'b1;
      end else if (!gu_r[0]) begin
        gu_r <= gu_r >> 1;
      end else if (!gv_r[0]) begin
        gv_r <= gv_r >> 1;
      end else begin
        gu_r <= (gu_r < gv_r) ? gu_r : gv_r;
        gv_r <= gdiff >> 1;
      end
    end
    if (cmd.dload) begin
      g_r      <= gu_r << gk_r;
      q_r      <= num_r;
      rem_r    <= '0;
      dc_r     <= '0;
    end
    if (cmd.dstep) begin
      if (rem_sh >= {1'b0, g_r}) begin
        rem_r <= M'(rem_sh - {1'b0, g_r});
        q_r   <= {q_r[M-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[M-1:0];
        q_r   <= {q_r[M-2:0], 1'b0};
      end
      dc_r <= dc_r + 1'b1;
    end
    if (cmd.dswap) begin
      nq_r     <= q_r;
      q_r      <= den_r;
      rem_r    <= '0;
      dc_r     <= '0;
    end
    if (cmd.finish) begin
      logic [M-1:0] lim;
      lim = M'(1) << (W - 1);
      res_order <= '0;
      if (early_st_r != rau_pkg::ST_OK) begin
        res_num <= '0; res_den <= '0; res_status <= early_st_r;
      end else if (kind_r == rau_pkg::KIND_CMP) begin
        res_num <= '0; res_den <= '0; res_status <= rau_pkg::ST_OK;
        res_order <= order_r;
      end else if (q_r > lim - 1'b1 || (nneg_r ? nq_r > lim : nq_r > lim - 1'b1)) begin
        res_num <= '0; res_den <= '0; res_status <= rau_pkg::ST_OVF;
      end else begin
        res_num    <= nneg_r ? 32'(-nq_r) : 32'(nq_r);
        res_den    <= 31'(q_r);
        res_status <= rau_pkg::ST_OK;
      end
    end
  end

  assign stat.early  = (early_st_r != rau_pkg::ST_OK);
  assign stat.is_cmp = (kind_r == rau_pkg::KIND_CMP);
  assign stat.unary  = (kind_r >= rau_pkg::KIND_NORM);
  assign stat.gdone  = (gv_r == '0) && (gu_r != '0);
  assign stat.ddone  = (dc_r == rau_pkg::CntW'(M));

endmodule

FILE: hdl/rau_ctrl.sv
// Controller state machine sequencing one rational operation at a time.
module rau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DLOAD, S_DIVN, S_DIVD, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE:  begin
        // The result cycle still counts as busy, so no transaction starts then.
        if (start && !done_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = stat.early ? S_FIN : (stat.unary ? S_COMB : S_MUL1);
      S_MUL1:  begin cmd.mul1 = 1'b1; state_nxt = S_MUL2; end
      S_MUL2:  begin cmd.mul2 = 1'b1; state_nxt = S_COMB; end
      S_COMB:  begin
        cmd.combine = 1'b1;
        state_nxt   = stat.is_cmp ? S_FIN : S_GCD;
      end
      S_GCD:   begin
        if (stat.gdone) state_nxt = S_DLOAD;
        else cmd.gstep = 1'b1;
      end
      S_DLOAD: begin cmd.dload = 1'b1; state_nxt = S_DIVN; end
      S_DIVN:  begin
        if (stat.ddone) begin
          cmd.dswap = 1'b1;
          state_nxt = S_DIVD;
        end else cmd.dstep = 1'b1;
      end
      S_DIVD:  begin
        if (stat.ddone) state_nxt = S_FIN;
        else cmd.dstep = 1'b1;
      end
      S_FIN:   begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT:   begin
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held longer than one cycle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_fin_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> ##1 done_r) else $error("finish not followed by done");
`endif

endmodule

FILE: hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// Errors go straight to the result, compare skips the gcd and divisions, normalize skips the products.
// The gcd loop (one binary step a cycle) and two 64-step divisions dominate.
// One transaction at a time: busy stays high from acceptance until the out_valid cycle ends.
// The result appears for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset returns the controller to idle.
module rational_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        out_valid,
  output logic [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic [1:0]  out_order,
  output logic [1:0]  out_status
);

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(out_valid)
  );

  rau_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_kind(in_kind), .in_a_num(in_a_num),
    .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den), .stat(stat),
    .res_num(out_res_num), .res_den(out_res_den), .res_order(out_order),
    .res_status(out_status)
  );

endmodule

FILE: verif/rau_checker.sv
// Checker that predicts each rational arithmetic result and compares it with the block.
module rau_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  input  logic        out_valid,
  input  logic [31:0] out_res_num,
  input  logic [30:0] out_res_den,
  input  logic [1:0]  out_order,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  order;
    logic [1:0]  status;
  } rat_result_t;

  rat_result_t expected_results[$];

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rat_result_t compute_rational(logic [2:0] kind, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    rat_result_t r;
    logic signed [127:0] san, sad, sbn, sbd, num, den, l, rr;
    logic [127:0] nm, dm, g;
    logic neg;
    r = '0;
    san = $signed(an);
    sad = $signed(ad);
    sbn = $signed(bn);
    sbd = $signed(bd);
    if (ad == 0 || (kind < rau_pkg::KIND_NORM && bd == 0)) begin
      r.status = rau_pkg::ST_ZDEN;
      return r;
    end
    if (kind == rau_pkg::KIND_CMP) begin
      if (sad < 0) begin
        san = -san;
        sad = -sad;
      end
      if (sbd < 0) begin
        sbn = -sbn;
        sbd = -sbd;
      end
      l = san * sbd;
      rr = sbn * sad;
      r.order = (l < rr) ? rau_pkg::ORD_LT : (l == rr) ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT;
      return r;
    end
    if (kind == rau_pkg::KIND_DIV && bn == 0) begin
      r.status = rau_pkg::ST_DIV0;
      return r;
    end
    case (kind)
      rau_pkg::KIND_ADD: begin
        num = san * sbd + sbn * sad;
        den = sad * sbd;
      end
      rau_pkg::KIND_SUB: begin
        num = san * sbd - sbn * sad;
        den = sad * sbd;
      end
      rau_pkg::KIND_MUL: begin
        num = san * sbn;
        den = sad * sbd;
      end
      rau_pkg::KIND_DIV: begin
        num = san * sbd;
        den = sad * sbn;
      end
      default: begin
        num = san;
        den = sad;
      end
    endcase
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    g = (nm == 0) ? dm : 128'(gcd64(nm[63:0], dm[63:0]));
    nm = nm / g;
    dm = dm / g;
    neg = ((num < 0) != (den < 0)) && nm != 0;
    if (dm > 128'h7fffffff || (neg ? nm > 128'h80000000 : nm > 128'h7fffffff)) begin
      r.status = rau_pkg::ST_OVF;
    end else begin
      r.num = neg ? -nm[31:0] : nm[31:0];
      r.den = dm[30:0];
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    rat_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result num=%h den=%h", out_res_num,
              out_res_den);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r != {out_res_num, out_res_den, out_order, out_status}) begin
            if (fail_count < 10)
              $display("mismatch: exp num=%h den=%h ord=%0d st=%0d got %h %h %0d %0d",
                  exp_r.num, exp_r.den, exp_r.order, exp_r.status, out_res_num,
                  out_res_den, out_order, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Pushed after the pop so a same-edge result never matches its own transaction.
      if (start && !busy)
        expected_results.push_back(compute_rational(in_kind, in_a_num, in_a_den, in_b_num,
            in_b_den));
    end
  end
endmodule

FILE: verif/tb.sv
// Testbench top: drives operand transactions into the rational arithmetic unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0, start = 0, busy, out_valid;
  logic [2:0] in_kind = 0;
  logic [31:0] in_a_num = 0, in_a_den = 1, in_b_num = 0, in_b_den = 1;
  logic [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0] out_order, out_status;
  int fail_count, pending, result_count, idle_cycles, sent;

  always #2 clk = ~clk;

  rational_arith_unit dut (.*);
  rau_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'(int'($urandom_range(0, 20)) - 10);
      3: return 32'hffffffff;
      4, 5: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 5);
    repeat (gap) @(negedge clk);
    in_kind = k;
    in_a_num = an;
    in_a_den = ad;
    in_b_num = bn;
    in_b_den = bd;
    start <= 1;
    // Busy only changes at rising edges, so checking it at the falling edge is stable.
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    start <= 0;
    sent++;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1;
    // Directed: every kind, extreme operands, zero denominators and divide by zero.
    for (int k = 0; k < 8; k++) send_op(3'(k), 32'h80000000, 32'h7fffffff, 32'h7fffffff,
        32'h80000000);
    send_op(rau_pkg::KIND_ADD, 0, 5, 0, -7);
    send_op(rau_pkg::KIND_SUB, 3, 0, 1, 2);
    send_op(rau_pkg::KIND_MUL, 3, 4, 1, 0);
    send_op(rau_pkg::KIND_NORM, 3, 0, 1, 0);
    send_op(3'd6, 6, -4, 1, 0);
    send_op(rau_pkg::KIND_DIV, 3, 4, 0, 5);
    send_op(rau_pkg::KIND_CMP, 1, 2, 2, 4);
    send_op(rau_pkg::KIND_CMP, -1, 2, 1, -3);
    send_op(rau_pkg::KIND_CMP, 4, 0, 1, 1);
    send_op(rau_pkg::KIND_MUL, 32'h80000000, 1, 32'hffffffff, 1);
    send_op(rau_pkg::KIND_NORM, 32'h80000000, -1, 0, 0);
    send_op(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(rau_pkg::KIND_ADD, 32'h7fffffff, 1, 32'h7fffffff, 1);
    for (int i = 0; i < 1500; i++) begin
      if (i % 200 < 20) begin
        // A stretch with fully random kinds and bit-rich operands.
        send_op(3'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        send_op(3'($urandom_range(0, 7)), pick_operand(), pick_operand(), pick_operand(),
            pick_operand());
      end
    end
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions, %0d results checked", sent, result_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
